@@ hw/rtl/ntc_pkg.sv @@
// Shared constants, register indexes and the log2 table generator for the NTC converter.
`default_nettype none

package ntc_pkg;

  localparam int LOG_FRAC   = 24;
  localparam int LOG_LAT    = 9;
  localparam int V_W        = 23;
  localparam int TEMP_W     = 18;
  localparam int RAIL_UV    = 10000;
  localparam int KELVIN_OFS = 27315;
  localparam int TEMP_HIGH  = 100000;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // configuration register indexes
  localparam logic [2:0] REG_SUPPLY   = 3'd0;
  localparam logic [2:0] REG_FIXED_R  = 3'd1;
  localparam logic [2:0] REG_NOMINAL  = 3'd2;
  localparam logic [2:0] REG_BETA     = 3'd3;
  localparam logic [2:0] REG_T0       = 3'd4;
  localparam logic [2:0] REG_NTC_GND  = 3'd5;
  localparam logic [2:0] REG_USE_CAL  = 3'd6;

  // log2(1 + idx / 2^tbits) in Q24, by truncated repeated squaring
  function automatic logic [24:0] log_entry(input int idx, input int tbits);
    logic [63:0] m;
    logic [24:0] f;
    m = (64'd1 << 30) + (64'(idx) << (30 - tbits));
    f = '0;
    if (idx == (1 << tbits)) begin
      f = 25'd1 << LOG_FRAC;
    end else begin
      for (int k = 0; k < LOG_FRAC; k++) begin
        m = (m * m) >> 30;
        f = f << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          f[0] = 1'b1;
        end
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ntc_thermistor_temperature.sv @@
// NTC thermistor to temperature converter, Beta equation, fully pipelined.
// Input stream: one word per converter sample, adc_code and calibrated_millivolt.
// Output stream: one word per input word, in order: code echo, clamped node
// voltage in uV and temperature in 0.01 C, saturated to [-273.15, 1000.00].
// Configuration: write channel (cfg_addr, cfg_data), always ready, one register
// per write; write only while no words are in flight.
// The pipeline depth is set mostly by the two bit-per-stage dividers (59 + 18 stages)
// and the 9-stage log2 unit; the divide by full scale is a reciprocal multiply with
// one correction (2 stages).
// Throughput: one word per cycle while the output is not stalled.
// Reset clears all valid flags and loads the default register values; the input
// is not ready while reset is high. The nominal-resistance log2 unit settles after
// reset or a write, once the new value has passed through its stages.
// When the output is stalled the whole pipeline holds and the input is not ready;
// nothing is dropped or repeated.
`default_nettype none

module ntc_thermistor_temperature #(
  parameter int ADC_BITS       = 12,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // adc_code, calibrated_millivolt
  input  logic [((ADC_BITS + 20) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // code_echo, voltage_microvolt, temperature_centicelsius
  output logic [((ADC_BITS + 48) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_addr,
  input  logic [19:0]                          cfg_data
);
  import ntc_pkg::*;

  localparam int OUT_W = ((ADC_BITS + 48) / 8) * 8;
  localparam int XW    = ADC_BITS + V_W;
  localparam int HALF  = (1 << (ADC_BITS - 1)) - 1;
  localparam int VPW   = ADC_BITS + V_W;
  localparam int RPW   = ADC_BITS + V_W + 2;
  localparam int TPW   = ADC_BITS + V_W + 1;
  localparam int EPW   = XW + 24;

  localparam logic signed [24:0] RAIL_S  = 25'(RAIL_UV);
  localparam logic signed [31:0] RQ_OFS  = 32'(16 << LOG_FRAC);
  localparam logic signed [30:0] LN2_S   = {1'b0, LN2_Q30};
  localparam logic signed [18:0] KOFS_S  = 19'(KELVIN_OFS);
  localparam logic signed [18:0] THIGH_S = 19'(TEMP_HIGH);

  // ---------------- configuration ----------------
  logic [V_W-1:0] vcc_uv;
  logic [19:0]    rf, r0;
  logic [13:0]    beta;
  logic [15:0]    t0;
  logic           ntg, use_cal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcc_uv  <= V_W'(3300000);
      rf      <= 20'd10000;
      r0      <= 20'd10000;
      beta    <= 14'd3950;
      t0      <= 16'd29815;
      ntg     <= 1'b1;
      use_cal <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_SUPPLY:  vcc_uv  <= V_W'(cfg_data[12:0]) * V_W'(1000);
        REG_FIXED_R: rf      <= cfg_data;
        REG_NOMINAL: r0      <= cfg_data;
        REG_BETA:    beta    <= cfg_data[13:0];
        REG_T0:      t0      <= cfg_data[15:0];
        REG_NTC_GND: ntg     <= cfg_data[0];
        REG_USE_CAL: use_cal <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // constants derived from the registers
  logic [29:0] tb_r;
  logic [36:0] tn_r;
  logic [20:0] b100_r;
  logic [19:0] r0_eff;
  logic [30:0] y_r0;

  assign r0_eff = (r0 == '0) ? 20'd1 : r0;

  always_ff @(posedge clk) begin
    tb_r   <= 30'(t0) * 30'(beta);
    tn_r   <= 37'(tb_r) * 37'd100;
    b100_r <= 21'(beta) * 21'd100;
  end

  ntc_log2_pipe #(.TBL_BITS(LOG_TABLE_BITS)) u_log_r0 (
    .clk (clk),
    .en  (1'b1),
    .x   ({44'd0, r0_eff}),
    .y   (y_r0)
  );

  // ---------------- pipeline ----------------
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !rst;

  logic [ADC_BITS-1:0] in_code;
  logic [12:0]         in_cal;
  assign in_code = s_axis_tdata[ADC_BITS-1:0];
  assign in_cal  = s_axis_tdata[ADC_BITS+12:ADC_BITS];

  // S1: raw voltage numerator
  logic                s1_valid;
  logic [ADC_BITS-1:0] s1_code;
  logic [XW-1:0]       s1_x;
  logic [V_W-1:0]      s1_cal;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_code <= in_code;
      s1_x    <= XW'(in_code) * XW'(vcc_uv) + XW'(HALF);
      s1_cal  <= V_W'(in_cal) * V_W'(1000);
    end
  end

  // divide by full scale: reciprocal estimate is low by at most one, then one fix-up
  localparam int          FS    = (1 << ADC_BITS) - 1;
  localparam logic [23:0] RECIP = 24'((64'd1 << XW) / 64'(FS));

  logic [EPW-1:0]      est_prod;
  logic                d1_valid;
  logic [XW-1:0]       d1_x;
  logic [V_W-1:0]      d1_qe;
  logic [VPW-1:0]      d1_pay;
  logic [XW-1:0]       est_rem;
  logic                dv_valid;
  logic [V_W-1:0]      dv_q;
  logic [VPW-1:0]      dv_pay;

  assign est_prod = EPW'(s1_x) * EPW'(RECIP);
  assign est_rem  = d1_x - {d1_qe, {ADC_BITS{1'b0}}} + XW'(d1_qe);

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_x   <= s1_x;
      d1_qe  <= est_prod[XW+V_W-1:XW];
      d1_pay <= {s1_code, s1_cal};
      dv_q   <= (est_rem >= XW'(FS)) ? d1_qe + 1'b1 : d1_qe;
      dv_pay <= d1_pay;
    end
  end

  // S2: select and clamp, lower clamp last
  logic signed [24:0] sel_v, hi_v, clamp_v;
  logic               s2_valid;
  logic [ADC_BITS-1:0] s2_code;
  logic [V_W-1:0]     s2_v;

  always_comb begin
    sel_v   = use_cal ? $signed({2'b00, dv_pay[V_W-1:0]}) : $signed({2'b00, dv_q});
    hi_v    = $signed({2'b00, vcc_uv}) - RAIL_S;
    clamp_v = sel_v;
    if (clamp_v >= hi_v) begin
      clamp_v = hi_v;
    end
    if (clamp_v <= RAIL_S) begin
      clamp_v = RAIL_S;
    end
  end

  // S3: divider numerator and denominator
  logic signed [24:0] vs, vc, rnum, rden;
  logic               s3_valid;
  logic [ADC_BITS-1:0] s3_code;
  logic [V_W-1:0]     s3_v, s3_num, s3_den;
  logic               s3_den_bad, s3_num_bad;

  always_comb begin
    vs   = $signed({2'b00, s2_v});
    vc   = $signed({2'b00, vcc_uv});
    rnum = ntg ? vs : vc - vs;
    rden = ntg ? vc - vs : vs;
  end

  // S4: Rf * numerator
  logic               s4_valid;
  logic [ADC_BITS-1:0] s4_code;
  logic [V_W-1:0]     s4_v, s4_den;
  logic [42:0]        s4_prod;
  logic               s4_den_bad, s4_num_bad;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_code    <= dv_pay[VPW-1:V_W];
      s2_v       <= clamp_v[V_W-1:0];
      s3_code    <= s2_code;
      s3_v       <= s2_v;
      s3_num     <= rnum[V_W-1:0];
      s3_den     <= rden[V_W-1:0];
      s3_den_bad <= rden <= 25'sd0;
      s3_num_bad <= rnum <= 25'sd0;
      s4_code    <= s3_code;
      s4_v       <= s3_v;
      s4_den     <= s3_den;
      s4_den_bad <= s3_den_bad;
      s4_num_bad <= s3_num_bad;
      s4_prod    <= 43'(rf) * 43'(s3_num);
    end
  end

  // resistance in Q16 ohms
  logic           dr_valid;
  logic [58:0]    dr_q;
  logic [RPW-1:0] dr_pay;

  ntc_div_pipe #(.DW(V_W), .QW(59), .PW(RPW)) u_div_res (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s4_valid),
    .num       ({23'd0, s4_prod, 16'd0}),
    .den       (s4_den_bad ? 23'd1 : s4_den),
    .in_pay    ({s4_code, s4_v, s4_den_bad, s4_num_bad}),
    .out_valid (dr_valid),
    .quo       (dr_q),
    .out_pay   (dr_pay)
  );

  // S5: saturate and floor at 1 ohm
  logic [62:0]         rq;
  logic                s5_valid;
  logic [ADC_BITS-1:0] s5_code;
  logic [V_W-1:0]      s5_v;
  logic [62:0]         s5_rq;

  always_comb begin
    priority if (dr_pay[1]) begin
      rq = 63'd1 << 62;
    end else if (dr_pay[0]) begin
      rq = '0;
    end else begin
      rq = {4'd0, dr_q};
    end
    if (rq < 63'd65536) begin
      rq = 63'd65536;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_code <= dr_pay[RPW-1:V_W+2];
      s5_v    <= dr_pay[V_W+1:2];
      s5_rq   <= rq;
    end
  end

  logic [30:0] y_rq;

  ntc_log2_pipe #(.TBL_BITS(LOG_TABLE_BITS)) u_log_rq (
    .clk (clk),
    .en  (adv),
    .x   ({1'b0, s5_rq}),
    .y   (y_rq)
  );

  // payload beside the log2 unit
  logic [LOG_LAT-1:0]  lg_valid;
  logic [ADC_BITS-1:0] lg_code [LOG_LAT];
  logic [V_W-1:0]      lg_v    [LOG_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_code[0] <= s5_code;
      lg_v[0]    <= s5_v;
      for (int i = 1; i < LOG_LAT; i++) begin
        lg_code[i] <= lg_code[i-1];
        lg_v[i]    <= lg_v[i-1];
      end
    end
  end

  // S6..S13: ln, Beta equation terms, saturation test
  logic signed [31:0]  s6_lnq;
  logic signed [62:0]  s7_mp;
  logic                s8_neg;
  logic [61:0]         s8_mag;
  logic [61:0]         rnd;
  logic signed [31:0]  s9_ln;
  logic signed [47:0]  s10_p;
  logic signed [47:0]  s11_td;
  logic                s12_pos;
  logic [61:0]         s12_nd;
  logic [47:0]         s12_td;
  logic                s13_sat;
  logic [65:0]         s13_num;
  logic [47:0]         s13_den;
  logic                sat_c;

  logic [ADC_BITS-1:0] tl_code [8];
  logic [V_W-1:0]      tl_v    [8];
  logic [7:0]          tl_valid;

  assign rnd   = s8_mag + 62'(1 << 29);
  assign sat_c = !s12_pos || ({4'd0, s12_nd[61:18]} >= s12_td);

  // |ln| in Q24 stays below 2^30, so the top two bits of the rounded value are zero
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_lnq  <= $signed({1'b0, y_rq}) - RQ_OFS - $signed({1'b0, y_r0});
      s7_mp   <= 63'(s6_lnq) * 63'(LN2_S);
      s8_neg  <= s7_mp[62];
      s8_mag  <= s7_mp[62] ? 62'(-s7_mp) : 62'(s7_mp);
      s9_ln   <= s8_neg ? -$signed({2'b00, rnd[59:30]})
                        :  $signed({2'b00, rnd[59:30]});
      s10_p   <= 48'($signed({1'b0, t0})) * 48'(s9_ln);
      s11_td  <= $signed({3'd0, b100_r, 24'd0}) + s10_p;
      s12_pos <= s11_td > 48'sd0;
      s12_nd  <= {1'b0, tn_r, 24'd0} + 62'(s11_td[47:1]);
      s12_td  <= s11_td;
      s13_sat <= sat_c;
      s13_num <= sat_c ? 66'd0 : {4'd0, s12_nd};
      s13_den <= sat_c ? 48'd1 : s12_td;
      tl_code[0] <= lg_code[LOG_LAT-1];
      tl_v[0]    <= lg_v[LOG_LAT-1];
      for (int i = 1; i < 8; i++) begin
        tl_code[i] <= tl_code[i-1];
        tl_v[i]    <= tl_v[i-1];
      end
    end
  end

  // temperature in 0.01 K
  logic           dt_valid;
  logic [17:0]    dt_q;
  logic [TPW-1:0] dt_pay;

  ntc_div_pipe #(.DW(48), .QW(18), .PW(TPW)) u_div_temp (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (tl_valid[7]),
    .num       (s13_num),
    .den       (s13_den),
    .in_pay    ({tl_code[7], tl_v[7], s13_sat}),
    .out_valid (dt_valid),
    .quo       (dt_q),
    .out_pay   (dt_pay)
  );

  // output word
  logic signed [18:0] t_c, temp;

  always_comb begin
    t_c = $signed({1'b0, dt_q}) - KOFS_S;
    if (dt_pay[0] || t_c > THIGH_S) begin
      temp = THIGH_S;
    end else begin
      temp = t_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= OUT_W'({temp[TEMP_W-1:0], dt_pay[V_W:1], dt_pay[TPW-1:V_W+1]});
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      d1_valid      <= 1'b0;
      dv_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      s5_valid      <= 1'b0;
      lg_valid      <= '0;
      tl_valid      <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid      <= s_axis_tvalid;
      d1_valid      <= s1_valid;
      dv_valid      <= d1_valid;
      s2_valid      <= dv_valid;
      s3_valid      <= s2_valid;
      s4_valid      <= s3_valid;
      s5_valid      <= dr_valid;
      lg_valid      <= {lg_valid[LOG_LAT-2:0], s5_valid};
      tl_valid      <= {tl_valid[6:0], lg_valid[LOG_LAT-1]};
      m_axis_tvalid <= dt_valid;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ntc_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none

module ntc_div_pipe #(
  parameter int DW = 12,
  parameter int QW = 23,
  parameter int PW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DW+QW-1:0]   num,
  input  logic [DW-1:0]      den,
  input  logic [PW-1:0]      in_pay,
  output logic               out_valid,
  output logic [QW-1:0]      quo,
  output logic [PW-1:0]      out_pay
);
  import ntc_pkg::*;

  // numerator top DW bits must already be below the divisor
  logic          vld   [QW];
  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] wrk   [QW];
  logic [DW-1:0] den_s [QW];
  logic [PW-1:0] pay_s [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] w_in;
    logic [PW-1:0] p_in;
    logic [DW:0]   shifted;
    logic [DW+1:0] trial;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = num[DW+QW-1:QW];
      assign w_in = num[QW-1:0];
      assign d_in = den;
      assign p_in = in_pay;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign r_in = rem_s[k-1];
      assign w_in = wrk[k-1];
      assign d_in = den_s[k-1];
      assign p_in = pay_s[k-1];
    end

    assign shifted = {r_in, w_in[QW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= trial[DW+1] ? shifted[DW-1:0] : trial[DW-1:0];
        wrk[k]   <= {w_in[QW-2:0], ~trial[DW+1]};
        den_s[k] <= d_in;
        pay_s[k] <= p_in;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = wrk[QW-1];
  assign out_pay   = pay_s[QW-1];

endmodule

`default_nettype wire

@@ hw/rtl/ntc_log2_pipe.sv @@
// Pipelined log2 in Q24: shift normaliser, table read, interpolation.
`default_nettype none

module ntc_log2_pipe #(
  parameter int TBL_BITS = 8
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [30:0] y
);
  import ntc_pkg::*;

  localparam int TBL_N = (1 << TBL_BITS) + 1;
  localparam int W_W   = 32 - TBL_BITS;
  localparam int PR_W  = 25 + W_W;

  logic [24:0] tbl [TBL_N];

  for (genvar gi = 0; gi < TBL_N; gi++) begin : g_tbl
    assign tbl[gi] = log_entry(gi, TBL_BITS);
  end

  // normaliser: shift by 32, 16, .. 1 until bit 63 is set
  logic [63:0] nx [6];
  logic [5:0]  np [6];

  for (genvar j = 0; j < 6; j++) begin : g_norm
    localparam int S = 32 >> j;
    logic [63:0] cur_x;
    logic [5:0]  cur_p;

    if (j == 0) begin : g_first
      assign cur_x = x;
      assign cur_p = 6'd63;
    end else begin : g_next
      assign cur_x = nx[j-1];
      assign cur_p = np[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur_x[63 -: S] == '0) begin
          nx[j] <= cur_x << S;
          np[j] <= cur_p - 6'(S);
        end else begin
          nx[j] <= cur_x;
          np[j] <= cur_p;
        end
      end
    end
  end

  logic [31:0]         frac;
  logic [TBL_BITS:0]   idx_lo;
  logic [TBL_BITS:0]   idx_hi;

  assign frac   = nx[5][62:31];
  assign idx_lo = {1'b0, frac[31 -: TBL_BITS]};
  assign idx_hi = idx_lo + 1'b1;

  logic [24:0]     lo1, d1, lo2;
  logic [W_W-1:0]  w1;
  logic [5:0]      p1, p2;
  logic [PR_W-1:0] prod2;

  always_ff @(posedge clk) begin
    if (en) begin
      lo1   <= tbl[idx_lo];
      d1    <= tbl[idx_hi] - tbl[idx_lo];
      w1    <= frac[W_W-1:0];
      p1    <= np[5];
      prod2 <= PR_W'(d1) * PR_W'(w1);
      lo2   <= lo1;
      p2    <= p1;
      y     <= 31'({p2, 24'd0}) + 31'(lo2) + 31'(prod2[PR_W-1:W_W]);
    end
  end

endmodule

`default_nettype wire
